@@ rtl/tgr_pkg.sv @@
// shared types, codes and helpers of the touch gesture recognizer
// no dependencies; imported by every rtl module of the block
package tgr_pkg;

    localparam int COORD_BITS = 10;
    localparam int DIFF_W     = COORD_BITS + 1;   // signed coordinate step
    localparam int SPAN_W     = COORD_BITS + 1;   // manhattan span
    localparam int GRID_W     = COORD_BITS + 1;   // grid size register
    localparam int DX_W       = COORD_BITS + 2;
    localparam int DY_W       = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;

    typedef logic [COORD_BITS-1:0] t_coord;

    // input kinds
    localparam logic [2:0] K_DOWN   = 3'd0;
    localparam logic [2:0] K_MOVE   = 3'd1;
    localparam logic [2:0] K_UP     = 3'd2;
    localparam logic [2:0] K_CANCEL = 3'd3;
    localparam logic [2:0] K_TICK   = 3'd4;

    // gesture codes
    localparam logic [2:0] G_NONE   = 3'd0;
    localparam logic [2:0] G_TAP    = 3'd1;
    localparam logic [2:0] G_LONG   = 3'd2;
    localparam logic [2:0] G_DRAG   = 3'd3;
    localparam logic [2:0] G_SWIPE  = 3'd4;
    localparam logic [2:0] G_SCROLL = 3'd5;
    localparam logic [2:0] G_PINCH  = 3'd6;

    // swipe start edges
    localparam logic [2:0] E_NONE   = 3'd0;
    localparam logic [2:0] E_LEFT   = 3'd1;
    localparam logic [2:0] E_RIGHT  = 3'd2;
    localparam logic [2:0] E_TOP    = 3'd3;
    localparam logic [2:0] E_BOTTOM = 3'd4;

    // emulated mouse
    localparam logic [1:0] BTN_LEFT     = 2'd0;
    localparam logic [1:0] BTN_WHEEL_UP = 2'd1;
    localparam logic [1:0] BTN_WHEEL_DN = 2'd2;
    localparam logic [1:0] ACT_PRESS    = 2'd0;
    localparam logic [1:0] ACT_DRAG     = 2'd1;
    localparam logic [1:0] ACT_RELEASE  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_TAP_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [1:0] CFG_GRID_W     = 2'd2;
    localparam logic [1:0] CFG_GRID_H     = 2'd3;

    localparam logic [15:0]       TAP_LIMIT_RST  = 16'd300;
    localparam logic [15:0]       LONG_PRESS_RST = 16'd500;

    typedef struct packed {
        logic [15:0]       tap_limit_ms;
        logic [15:0]       long_press_ms;
        logic [GRID_W-1:0] grid_width;
        logic [GRID_W-1:0] grid_height;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  finger_slot;
        t_coord      cell_x;
        t_coord      cell_y;
        logic [31:0] time_ms;
    } t_item;

    typedef struct packed {
        logic [2:0]             gesture_type;
        logic [1:0]             finger_count;
        t_coord                 gesture_x;
        t_coord                 gesture_y;
        logic signed [DX_W-1:0] delta_x;
        logic signed [DY_W-1:0] delta_y;
        logic [2:0]             edge_res;
        logic                   mouse_valid;
        t_coord                 mouse_x;
        t_coord                 mouse_y;
        logic [1:0]             mouse_button;
        logic [1:0]             mouse_action;
    } t_result;

    function automatic logic [SPAN_W-1:0] span_of(t_coord c0, t_coord r0,
                                                  t_coord c1, t_coord r1);
        t_coord dc;
        t_coord dr;
        dc = (c0 > c1) ? (c0 - c1) : (c1 - c0);
        dr = (r0 > r1) ? (r0 - r1) : (r1 - r0);
        return {1'b0, dc} + {1'b0, dr};
    endfunction

endpackage

@@ rtl/touch_gesture_recognizer.sv @@
// touch gesture recognizer: touch events in, one gesture/mouse result per event out
// slave stream carries events, master stream results, a separate port writes config
// instantiates tgr_engine and tgr_obuf; depends on tgr_pkg
//
// usage:
//   - every beat accepted on the slave side yields exactly one beat on the master
//     side; gesture_type none means nothing was recognized for that event
//   - a result passes the input register, then the decision logic into the result
//     buffer, before it is offered; while the buffer is full the event waits in the
//     input register
//   - throughput: one event per cycle while the result buffer has room; the decision
//     path that reads and updates the two finger slots is combinational
//   - the cfg port is always ready; write it only while no events are in flight
//   - reset: registers return to tap 300 ms, long press 500 ms, grid 0 x 0, all
//     finger slots are cleared at once and the block accepts beats right away
//   - master stall: the two-entry result buffer and the input register absorb
//     up to three events, then o_s_tready drops until results are taken
module touch_gesture_recognizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // finger_slot[3:0], cell_x[13:4], cell_y[23:14],
                                     // time_ms[55:24]
    input  logic [2:0]  i_s_tuser,   // kind[2:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // finger_count[1:0], gesture_x[11:2], gesture_y[21:12],
                                     // delta_x[33:22], delta_y[44:34], edge_res[47:45],
                                     // mouse_x[57:48], mouse_y[67:58],
                                     // mouse_button[69:68], mouse_action[71:70]
    output logic [3:0]  o_m_tuser,   // gesture_type[2:0], mouse_valid[3]
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import tgr_pkg::*;

    t_cfg    r_cfg;
    t_item   r_in;
    logic    r_in_valid;
    logic    s_acc, fire, buf_full;
    t_result res, out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_limit_ms  <= TAP_LIMIT_RST;
            r_cfg.long_press_ms <= LONG_PRESS_RST;
            r_cfg.grid_width    <= '0;
            r_cfg.grid_height   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TAP_LIMIT:  r_cfg.tap_limit_ms  <= i_cfg_data;
                CFG_LONG_PRESS: r_cfg.long_press_ms <= i_cfg_data;
                CFG_GRID_W:     r_cfg.grid_width    <= i_cfg_data[GRID_W-1:0];
                CFG_GRID_H:     r_cfg.grid_height   <= i_cfg_data[GRID_W-1:0];
            endcase
        end
    end

    // input register advances whenever the result buffer has room
    assign fire       = r_in_valid && !buf_full;
    assign o_s_tready = !r_in_valid || !buf_full;
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_in_valid <= 1'b0;
        else
            r_in_valid <= s_acc || (r_in_valid && !fire);
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in.kind        <= i_s_tuser;
            r_in.finger_slot <= i_s_tdata[3:0];
            r_in.cell_x      <= i_s_tdata[13:4];
            r_in.cell_y      <= i_s_tdata[23:14];
            r_in.time_ms     <= i_s_tdata[55:24];
        end
    end

    tgr_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_res   (res)
    );

    tgr_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fire),
        .i_data  (res),
        .o_full  (buf_full),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (out_res)
    );

    assign o_m_tdata = {out_res.mouse_action, out_res.mouse_button,
                        out_res.mouse_y, out_res.mouse_x, out_res.edge_res,
                        out_res.delta_y, out_res.delta_x,
                        out_res.gesture_y, out_res.gesture_x, out_res.finger_count};
    assign o_m_tuser = {out_res.mouse_valid, out_res.gesture_type};

endmodule

@@ rtl/tgr_engine.sv @@
// finger slot state and the single-pass gesture decision for one event
// depends on tgr_pkg; result goes to the output buffer in the same cycle
module tgr_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tgr_pkg::t_cfg   i_cfg,
    input  logic            i_fire,
    input  tgr_pkg::t_item  i_item,
    output tgr_pkg::t_result o_res
);
    import tgr_pkg::*;

    logic                    r_act   [2], n_act   [2];
    logic [3:0]              r_id    [2], n_id    [2];
    t_coord                  r_scol  [2], n_scol  [2];
    t_coord                  r_srow  [2], n_srow  [2];
    t_coord                  r_ncol  [2], n_ncol  [2];
    t_coord                  r_nrow  [2], n_nrow  [2];
    logic [31:0]             r_ptime [2], n_ptime [2];
    logic                    r_left  [2], n_left  [2];
    logic [1:0]              r_cnt, n_cnt;
    logic                    r_lpd, n_lpd;
    logic                    r_sfs, n_sfs;
    logic [SPAN_W-1:0]       r_span, n_span;

    t_coord x, y;
    logic   hit0, hit1, found, fidx, free_ok, dsel;
    logic   cnt_ge2;

    logic signed [DIFF_W-1:0] dx, dy, a0, b0, a1, b1;
    logic signed [PROD_W-1:0] p0, p1;
    logic [PROD_W:0]          dot;
    t_coord                   mcol [2], mrow [2], dcol [2], drow [2];
    logic [SPAN_W-1:0]        mspan, dspan;
    logic signed [DX_W-1:0]   pinch_d;
    logic [2:0]               edge_code;
    logic [31:0]              up_el, el0, el1;
    logic                     tap_ok, lp0, lp1;
    logic [1:0]               cnt_dec;

    function automatic logic [2:0] edge_of(t_coord c, t_coord r,
                                           logic [GRID_W-1:0] gw,
                                           logic [GRID_W-1:0] gh);
        logic [2:0] e;
        priority if (c == '0)
            e = E_LEFT;
        else if (gw != '0 && {1'b0, c} >= gw - GRID_W'(1))
            e = E_RIGHT;
        else if (r == '0)
            e = E_TOP;
        else if (gh != '0 && {1'b0, r} >= gh - GRID_W'(1))
            e = E_BOTTOM;
        else
            e = E_NONE;
        return e;
    endfunction

    assign x = i_item.cell_x;
    assign y = i_item.cell_y;

    // slot lookup; active ids are unique, slot 0 wins otherwise
    assign hit0    = r_act[0] && (r_id[0] == i_item.finger_slot);
    assign hit1    = r_act[1] && (r_id[1] == i_item.finger_slot);
    assign found   = hit0 || hit1;
    assign fidx    = !hit0;
    assign free_ok = !r_act[0] || !r_act[1];
    assign dsel    = found ? fidx : r_act[0];
    assign cnt_ge2 = r_cnt >= 2'd2;

    assign dx = $signed({1'b0, x}) - $signed({1'b0, r_ncol[fidx]});
    assign dy = $signed({1'b0, y}) - $signed({1'b0, r_nrow[fidx]});

    // positions as they stand after this move / this down
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            mcol[k] = (found && fidx == k[0]) ? x : r_ncol[k];
            mrow[k] = (found && fidx == k[0]) ? y : r_nrow[k];
            dcol[k] = (dsel == k[0]) ? x : r_ncol[k];
            drow[k] = (dsel == k[0]) ? y : r_nrow[k];
        end
    end

    assign a0 = $signed({1'b0, mcol[0]}) - $signed({1'b0, r_scol[0]});
    assign b0 = $signed({1'b0, mrow[0]}) - $signed({1'b0, r_srow[0]});
    assign a1 = $signed({1'b0, mcol[1]}) - $signed({1'b0, r_scol[1]});
    assign b1 = $signed({1'b0, mrow[1]}) - $signed({1'b0, r_srow[1]});
    assign p0 = a0 * a1;
    assign p1 = b0 * b1;
    assign dot = {p0[PROD_W-1], p0} + {p1[PROD_W-1], p1};

    assign mspan   = span_of(mcol[0], mrow[0], mcol[1], mrow[1]);
    assign dspan   = span_of(dcol[0], drow[0], dcol[1], drow[1]);
    assign pinch_d = $signed({1'b0, mspan}) - $signed({1'b0, r_span});
    assign edge_code = edge_of(r_scol[fidx], r_srow[fidx],
                               i_cfg.grid_width, i_cfg.grid_height);

    // time differences wrap modulo 2^32
    assign up_el  = i_item.time_ms - r_ptime[fidx];
    assign el0    = i_item.time_ms - r_ptime[0];
    assign el1    = i_item.time_ms - r_ptime[1];
    assign tap_ok = up_el < {16'd0, i_cfg.tap_limit_ms};
    assign lp0    = r_act[0] && !r_left[0] && (el0 >= {16'd0, i_cfg.long_press_ms});
    assign lp1    = r_act[1] && !r_left[1] && (el1 >= {16'd0, i_cfg.long_press_ms});
    assign cnt_dec = (r_cnt != 2'd0) ? r_cnt - 2'd1 : 2'd0;

    always_comb begin
        n_act   = r_act;
        n_id    = r_id;
        n_scol  = r_scol;
        n_srow  = r_srow;
        n_ncol  = r_ncol;
        n_nrow  = r_nrow;
        n_ptime = r_ptime;
        n_left  = r_left;
        n_cnt   = r_cnt;
        n_lpd   = r_lpd;
        n_sfs   = r_sfs;
        n_span  = r_span;
        o_res   = '0;

        unique case (i_item.kind)
            K_DOWN: begin
                if (found || free_ok) begin
                    n_act[dsel]   = 1'b1;
                    n_id[dsel]    = i_item.finger_slot;
                    n_scol[dsel]  = x;
                    n_ncol[dsel]  = x;
                    n_srow[dsel]  = y;
                    n_nrow[dsel]  = y;
                    n_ptime[dsel] = i_item.time_ms;
                    n_left[dsel]  = 1'b0;
                    if (!found && r_cnt < 2'd2)
                        n_cnt = r_cnt + 2'd1;
                    n_lpd = 1'b0;
                    if (n_cnt >= 2'd2) begin
                        n_sfs  = 1'b1;
                        n_span = dspan;
                    end
                    o_res.mouse_valid  = 1'b1;
                    o_res.mouse_x      = x;
                    o_res.mouse_y      = y;
                    o_res.mouse_button = BTN_LEFT;
                    o_res.mouse_action = ACT_PRESS;
                end
            end
            K_MOVE: begin
                if (found) begin
                    n_ncol[fidx] = x;
                    n_nrow[fidx] = y;
                    if (x != r_scol[fidx] || y != r_srow[fidx])
                        n_left[fidx] = 1'b1;
                    if (cnt_ge2) begin
                        // a finger still on its start cell blocks two-finger gestures
                        if (!((a0 == '0 && b0 == '0) || (a1 == '0 && b1 == '0))) begin
                            o_res.finger_count = r_cnt;
                            o_res.gesture_x    = x;
                            o_res.gesture_y    = y;
                            if (dot[PROD_W]) begin
                                n_span             = mspan;
                                o_res.gesture_type = G_PINCH;
                                o_res.delta_x      = pinch_d;
                            end else begin
                                o_res.gesture_type = G_SCROLL;
                                o_res.delta_x      = DX_W'(dx);
                                o_res.delta_y      = dy;
                                if (dy != '0) begin
                                    o_res.mouse_valid  = 1'b1;
                                    o_res.mouse_x      = x;
                                    o_res.mouse_y      = y;
                                    o_res.mouse_button = dy[DIFF_W-1] ? BTN_WHEEL_UP
                                                                      : BTN_WHEEL_DN;
                                    o_res.mouse_action = ACT_PRESS;
                                end
                            end
                        end
                    end else if (dx != '0 || dy != '0) begin
                        o_res.mouse_valid  = 1'b1;
                        o_res.mouse_x      = x;
                        o_res.mouse_y      = y;
                        o_res.mouse_button = BTN_LEFT;
                        o_res.mouse_action = ACT_DRAG;
                        o_res.gesture_type = (edge_code != E_NONE) ? G_SWIPE : G_DRAG;
                        o_res.finger_count = 2'd1;
                        o_res.gesture_x    = x;
                        o_res.gesture_y    = y;
                        o_res.delta_x      = DX_W'(dx);
                        o_res.delta_y      = dy;
                        o_res.edge_res     = edge_code;
                    end
                end
            end
            K_UP: begin
                if (found) begin
                    o_res.mouse_valid  = 1'b1;
                    o_res.mouse_x      = r_ncol[fidx];
                    o_res.mouse_y      = r_nrow[fidx];
                    o_res.mouse_button = BTN_LEFT;
                    o_res.mouse_action = ACT_RELEASE;
                    n_act[fidx] = 1'b0;
                    n_cnt       = cnt_dec;
                    if (cnt_dec == 2'd0) begin
                        n_sfs = 1'b0;
                        n_lpd = 1'b0;
                    end
                    if (!r_left[fidx] && !r_sfs && !r_lpd && tap_ok) begin
                        o_res.gesture_type = G_TAP;
                        o_res.finger_count = 2'd1;
                        o_res.gesture_x    = r_ncol[fidx];
                        o_res.gesture_y    = r_nrow[fidx];
                    end
                end
            end
            K_TICK: begin
                if (r_cnt == 2'd1 && !r_lpd && !r_sfs && (lp0 || lp1)) begin
                    n_lpd              = 1'b1;
                    o_res.gesture_type = G_LONG;
                    o_res.finger_count = 2'd1;
                    o_res.gesture_x    = lp0 ? r_ncol[0] : r_ncol[1];
                    o_res.gesture_y    = lp0 ? r_nrow[0] : r_nrow[1];
                end
            end
            default: begin
                // cancel and unused kinds drop all tracking
                for (int k = 0; k < 2; k++) begin
                    n_act[k]   = 1'b0;
                    n_id[k]    = '0;
                    n_scol[k]  = '0;
                    n_srow[k]  = '0;
                    n_ncol[k]  = '0;
                    n_nrow[k]  = '0;
                    n_ptime[k] = '0;
                    n_left[k]  = 1'b0;
                end
                n_cnt  = '0;
                n_lpd  = 1'b0;
                n_sfs  = 1'b0;
                n_span = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_act[k]   <= 1'b0;
                r_id[k]    <= '0;
                r_scol[k]  <= '0;
                r_srow[k]  <= '0;
                r_ncol[k]  <= '0;
                r_nrow[k]  <= '0;
                r_ptime[k] <= '0;
                r_left[k]  <= 1'b0;
            end
            r_cnt  <= '0;
            r_lpd  <= 1'b0;
            r_sfs  <= 1'b0;
            r_span <= '0;
        end else if (i_fire) begin
            r_act   <= n_act;
            r_id    <= n_id;
            r_scol  <= n_scol;
            r_srow  <= n_srow;
            r_ncol  <= n_ncol;
            r_nrow  <= n_nrow;
            r_ptime <= n_ptime;
            r_left  <= n_left;
            r_cnt   <= n_cnt;
            r_lpd   <= n_lpd;
            r_sfs   <= n_sfs;
            r_span  <= n_span;
        end
    end

endmodule

@@ rtl/tgr_obuf.sv @@
// two-entry result buffer between the engine and the master-side stream
// depends on tgr_pkg for the result record
module tgr_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  tgr_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_ready,
    output tgr_pkg::t_result o_data
);
    import tgr_pkg::*;

    t_result    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       rd;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];
    assign rd      = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr && !rd)
            n_cnt = r_cnt + 2'd1;
        else if (!i_wr && rd)
            n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr)
            r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_wr)
                r_wp <= !r_wp;
            if (rd)
                r_rp <= !r_rp;
        end
    end

endmodule

@@ sim/tb_touch_gesture_recognizer.sv @@
// self-checking testbench for touch_gesture_recognizer: directed and random touch
// sequences, an in-bench gesture predictor and a scoreboard on the result stream
// depends on rtl/tgr_pkg.sv and rtl/touch_gesture_recognizer.sv
`timescale 1ns / 100ps

module tb_touch_gesture_recognizer;
    import tgr_pkg::*;

    // kinds the block treats like cancel
    localparam logic [2:0] K_UNUSED_LO = 3'd5;
    localparam logic [2:0] K_UNUSED_HI = 3'd7;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 225;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [55:0] i_s_tdata = '0;
    logic [2:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;
    logic [3:0]  o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    touch_gesture_recognizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [15:0] cfg_tap = TAP_LIMIT_RST;
    logic [15:0] cfg_long = LONG_PRESS_RST;
    logic [10:0] cfg_gw = '0;
    logic [10:0] cfg_gh = '0;

    // predictor copy of the finger slots
    bit          f_on[2];
    bit   [3:0]  f_id[2];
    bit   [9:0]  f_col0[2];
    bit   [9:0]  f_row0[2];
    bit   [9:0]  f_col[2];
    bit   [9:0]  f_row[2];
    bit   [31:0] f_t0[2];
    bit          f_moved[2];
    int          n_down;
    bit          press_reported;
    bit          multi_touch;
    bit   [10:0] span_ref;

    t_item   touch_queue[$];
    t_result pending_results[$];
    int      error_count = 0;
    bit      tx_steady = 1'b0;
    bit      rx_steady = 1'b0;

    function automatic void clear_fingers();
        for (int k = 0; k < 2; k++) begin
            f_on[k] = 0;
            f_id[k] = '0;
            f_col0[k] = '0;
            f_row0[k] = '0;
            f_col[k] = '0;
            f_row[k] = '0;
            f_t0[k] = '0;
            f_moved[k] = 0;
        end
        n_down = 0;
        press_reported = 0;
        multi_touch = 0;
        span_ref = '0;
    endfunction

    function automatic int find_finger(logic [3:0] id);
        for (int k = 0; k < 2; k++)
            if (f_on[k] && f_id[k] == id) return k;
        return -1;
    endfunction

    function automatic int finger_span();
        int dc;
        int dr;
        if (n_down < 2) return 0;
        dc = int'(f_col[0]) - int'(f_col[1]);
        dr = int'(f_row[0]) - int'(f_row[1]);
        return (dc < 0 ? -dc : dc) + (dr < 0 ? -dr : dr);
    endfunction

    function automatic logic [2:0] entry_side(int s);
        if (f_col0[s] == 0) return E_LEFT;
        if (cfg_gw != 0 && int'(f_col0[s]) >= int'(cfg_gw) - 1) return E_RIGHT;
        if (f_row0[s] == 0) return E_TOP;
        if (cfg_gh != 0 && int'(f_row0[s]) >= int'(cfg_gh) - 1) return E_BOTTOM;
        return E_NONE;
    endfunction

    function automatic void put_mouse(ref t_result res, input logic [9:0] x, logic [9:0] y,
                                      logic [1:0] btn, logic [1:0] act);
        res.mouse_valid = 1'b1;
        res.mouse_x = x;
        res.mouse_y = y;
        res.mouse_button = btn;
        res.mouse_action = act;
    endfunction

    function automatic void put_gesture(ref t_result res, input logic [2:0] code, int cnt,
                                        logic [9:0] x, logic [9:0] y, int dx, int dy,
                                        logic [2:0] edge_code);
        res.gesture_type = code;
        res.finger_count = cnt[1:0];
        res.gesture_x = x;
        res.gesture_y = y;
        res.delta_x = dx[11:0];
        res.delta_y = dy[10:0];
        res.edge_res = edge_code;
    endfunction

    // expected result of one touch beat; updates the predictor state
    function automatic t_result gesture_step(t_item ev);
        t_result     res;
        int          s;
        int          dx;
        int          dy;
        int          a0;
        int          b0;
        int          a1;
        int          b1;
        int          span_now;
        bit          fresh;
        bit          tapped;
        bit          fired;
        logic [2:0]  edge_code;
        logic [31:0] held;
        res = '0;
        case (ev.kind)
            K_DOWN: begin
                s = find_finger(ev.finger_slot);
                fresh = 0;
                if (s < 0) begin
                    fresh = 1;
                    for (int k = 0; k < 2 && s < 0; k++)
                        if (!f_on[k]) s = k;
                end
                if (s >= 0) begin
                    f_on[s] = 1;
                    f_id[s] = ev.finger_slot;
                    f_col0[s] = ev.cell_x;
                    f_col[s] = ev.cell_x;
                    f_row0[s] = ev.cell_y;
                    f_row[s] = ev.cell_y;
                    f_t0[s] = ev.time_ms;
                    f_moved[s] = 0;
                    if (fresh && n_down < 2) n_down++;
                    press_reported = 0;
                    if (n_down >= 2) begin
                        multi_touch = 1;
                        span_now = finger_span();
                        span_ref = span_now[10:0];
                    end
                    put_mouse(res, ev.cell_x, ev.cell_y, BTN_LEFT, ACT_PRESS);
                end
            end
            K_MOVE: begin
                s = find_finger(ev.finger_slot);
                if (s >= 0) begin
                    dx = int'(ev.cell_x) - int'(f_col[s]);
                    dy = int'(ev.cell_y) - int'(f_row[s]);
                    f_col[s] = ev.cell_x;
                    f_row[s] = ev.cell_y;
                    if (ev.cell_x != f_col0[s] || ev.cell_y != f_row0[s]) f_moved[s] = 1;
                    if (n_down >= 2) begin
                        a0 = int'(f_col[0]) - int'(f_col0[0]);
                        b0 = int'(f_row[0]) - int'(f_row0[0]);
                        a1 = int'(f_col[1]) - int'(f_col0[1]);
                        b1 = int'(f_row[1]) - int'(f_row0[1]);
                        // nothing until both fingers have left their start cells
                        if (!((a0 == 0 && b0 == 0) || (a1 == 0 && b1 == 0))) begin
                            if (a0 * a1 + b0 * b1 < 0) begin
                                span_now = finger_span();
                                put_gesture(res, G_PINCH, n_down, ev.cell_x, ev.cell_y,
                                            span_now - int'(span_ref), 0, E_NONE);
                                span_ref = span_now[10:0];
                            end else begin
                                put_gesture(res, G_SCROLL, n_down, ev.cell_x, ev.cell_y,
                                            dx, dy, E_NONE);
                                if (dy != 0)
                                    put_mouse(res, ev.cell_x, ev.cell_y,
                                              dy < 0 ? BTN_WHEEL_UP : BTN_WHEEL_DN, ACT_PRESS);
                            end
                        end
                    end else if (dx != 0 || dy != 0) begin
                        put_mouse(res, ev.cell_x, ev.cell_y, BTN_LEFT, ACT_DRAG);
                        edge_code = entry_side(s);
                        put_gesture(res, edge_code != E_NONE ? G_SWIPE : G_DRAG, 1,
                                    ev.cell_x, ev.cell_y, dx, dy, edge_code);
                    end
                end
            end
            K_UP: begin
                s = find_finger(ev.finger_slot);
                if (s >= 0) begin
                    put_mouse(res, f_col[s], f_row[s], BTN_LEFT, ACT_RELEASE);
                    held = ev.time_ms - f_t0[s];
                    tapped = !f_moved[s] && !multi_touch && !press_reported && held < cfg_tap;
                    f_on[s] = 0;
                    if (n_down > 0) n_down--;
                    if (n_down == 0) begin
                        multi_touch = 0;
                        press_reported = 0;
                    end
                    if (tapped) put_gesture(res, G_TAP, 1, f_col[s], f_row[s], 0, 0, E_NONE);
                end
            end
            K_TICK: begin
                fired = 0;
                if (n_down == 1 && !press_reported && !multi_touch) begin
                    for (int k = 0; k < 2; k++) begin
                        held = ev.time_ms - f_t0[k];
                        if (!fired && f_on[k] && !f_moved[k] && held >= cfg_long) begin
                            fired = 1;
                            press_reported = 1;
                            put_gesture(res, G_LONG, 1, f_col[k], f_row[k], 0, 0, E_NONE);
                        end
                    end
                end
            end
            default: clear_fingers();
        endcase
        return res;
    endfunction

    // ---------------- touch driver ----------------
    t_item ev_cur;
    bit    ev_live = 0;
    int    ev_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ev_live = 0;
            ev_gap = 0;
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                pending_results.push_back(gesture_step(ev_cur));
                ev_live = 0;
                ev_gap = (tx_steady || $urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 8);
            end
            if (!ev_live) begin
                if (ev_gap > 0) begin
                    ev_gap--;
                end else if (touch_queue.size() > 0) begin
                    ev_cur = touch_queue.pop_front();
                    ev_live = 1;
                    i_s_tdata <= {ev_cur.time_ms, ev_cur.cell_y, ev_cur.cell_x,
                                  ev_cur.finger_slot};
                    i_s_tuser <= ev_cur.kind;
                end
            end
            i_s_tvalid <= ev_live;
        end
    end

    // ---------------- long receiver hold-off ----------------
    int hold_beats = 0;
    int hold_left = 0;
    bit rx_hold = 1'b0;

    // long back-pressure so the input side fills up and stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_beats = 0;
            hold_left = 0;
            rx_hold <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                hold_beats++;
                if (hold_beats == 300 || hold_beats == 900) hold_left = 150;
            end
            if (hold_left > 0) hold_left--;
            rx_hold <= hold_left > 0;
        end
    end

    // ---------------- result monitor ----------------
    t_result got;
    t_result want;
    int      rx_wait = 0;

    task automatic check_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wait = 0;
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.gesture_type = o_m_tuser[2:0];
                got.mouse_valid  = o_m_tuser[3];
                got.finger_count = o_m_tdata[1:0];
                got.gesture_x    = o_m_tdata[11:2];
                got.gesture_y    = o_m_tdata[21:12];
                got.delta_x      = o_m_tdata[33:22];
                got.delta_y      = o_m_tdata[44:34];
                got.edge_res     = o_m_tdata[47:45];
                got.mouse_x      = o_m_tdata[57:48];
                got.mouse_y      = o_m_tdata[67:58];
                got.mouse_button = o_m_tdata[69:68];
                got.mouse_action = o_m_tdata[71:70];
                if (pending_results.size() == 0) begin
                    $error("result beat with no gesture expected");
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("gesture_type", want.gesture_type, got.gesture_type);
                    check_field("finger_count", want.finger_count, got.finger_count);
                    check_field("gesture_x", want.gesture_x, got.gesture_x);
                    check_field("gesture_y", want.gesture_y, got.gesture_y);
                    check_field("delta_x", int'(want.delta_x), int'(got.delta_x));
                    check_field("delta_y", int'(want.delta_y), int'(got.delta_y));
                    check_field("edge_res", want.edge_res, got.edge_res);
                    check_field("mouse_valid", want.mouse_valid, got.mouse_valid);
                    check_field("mouse_x", want.mouse_x, got.mouse_x);
                    check_field("mouse_y", want.mouse_y, got.mouse_y);
                    check_field("mouse_button", want.mouse_button, got.mouse_button);
                    check_field("mouse_action", want.mouse_action, got.mouse_action);
                end
                rx_wait = (rx_steady || $urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 8);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= !rx_hold;
            end
        end
    end

    // ---------------- stimulus ----------------
    logic [31:0] gen_ms;
    bit          gen_on[16];
    int          gen_x[16];
    int          gen_y[16];
    logic [3:0]  pool[3];

    task automatic push_touch(logic [2:0] kind, logic [3:0] slot, int x, int y,
                              logic [31:0] t);
        t_item it;
        it.kind = kind;
        it.finger_slot = slot;
        it.cell_x = x[9:0];
        it.cell_y = y[9:0];
        it.time_ms = t;
        touch_queue.push_back(it);
    endtask

    task automatic wait_drained();
        while (touch_queue.size() != 0 || ev_live || pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_TAP_LIMIT:  cfg_tap = val;
            CFG_LONG_PRESS: cfg_long = val;
            CFG_GRID_W:     cfg_gw = val[10:0];
            CFG_GRID_H:     cfg_gh = val[10:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [3:0] pick_finger();
        int j;
        j = $urandom_range(0, 2);
        if ($urandom_range(0, 9) < 8)
            for (int k = 0; k < 3; k++)
                if (gen_on[pool[(j + k) % 3]]) return pool[(j + k) % 3];
        return pool[j];
    endfunction

    function automatic int clamp_cell(int v);
        return v < 0 ? 0 : (v > 1023 ? 1023 : v);
    endfunction

    task automatic random_touches(int count);
        int         r;
        logic [3:0] id;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0) gen_ms += $urandom_range(0, 800);
            else gen_ms += $urandom_range(0, 60);
            if (r < 22) begin
                id = pool[$urandom_range(0, 2)];
                case ($urandom_range(0, 7))
                    0: begin gen_x[id] = 0; gen_y[id] = $urandom_range(0, 1023); end
                    1: begin
                        gen_x[id] = cfg_gw == 0 ? 1023 : clamp_cell(int'(cfg_gw) - 1);
                        gen_y[id] = $urandom_range(1, 1023);
                    end
                    2: begin gen_x[id] = $urandom_range(1, 1022); gen_y[id] = 0; end
                    3: begin
                        gen_x[id] = $urandom_range(1, 1022);
                        gen_y[id] = cfg_gh == 0 ? 1023 : clamp_cell(int'(cfg_gh) - 1);
                    end
                    default: begin
                        gen_x[id] = $urandom_range(0, 1023);
                        gen_y[id] = $urandom_range(0, 1023);
                    end
                endcase
                gen_on[id] = 1;
                push_touch(K_DOWN, id, gen_x[id], gen_y[id], gen_ms);
            end else if (r < 60) begin
                id = pick_finger();
                if ($urandom_range(0, 15) == 0) begin
                    gen_x[id] = $urandom_range(0, 1023);
                    gen_y[id] = $urandom_range(0, 1023);
                end else begin
                    gen_x[id] = clamp_cell(gen_x[id] + $urandom_range(0, 8) - 4);
                    gen_y[id] = clamp_cell(gen_y[id] + $urandom_range(0, 8) - 4);
                end
                push_touch(K_MOVE, id, gen_x[id], gen_y[id], gen_ms);
            end else if (r < 80) begin
                id = pick_finger();
                gen_on[id] = 0;
                push_touch(K_UP, id, $urandom_range(0, 1023), $urandom_range(0, 1023), gen_ms);
            end else if (r < 92) begin
                push_touch(K_TICK, 4'($urandom_range(0, 15)), $urandom_range(0, 1023),
                           $urandom_range(0, 1023), gen_ms);
            end else if (r < 96) begin
                for (int k = 0; k < 16; k++) gen_on[k] = 0;
                push_touch(r < 94 ? K_CANCEL : 3'($urandom_range(K_UNUSED_LO, K_UNUSED_HI)),
                           4'($urandom_range(0, 15)), $urandom_range(0, 1023),
                           $urandom_range(0, 1023), gen_ms);
            end else begin
                // noise beat with every field random
                push_touch(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                           $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
            end
        end
    endtask

    initial begin
        clear_fingers();
        for (int k = 0; k < 16; k++) begin
            gen_on[k] = 0;
            gen_x[k] = 0;
            gen_y[k] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, reset register values
        push_touch(K_DOWN, 3, 0, 0, 100);
        push_touch(K_UP, 3, 1023, 1023, 250);                    // tap
        push_touch(K_TICK, 15, 1023, 0, 300);                    // tick, no finger
        push_touch(K_DOWN, 5, 1023, 1023, 32'hFFFF_FF00);
        push_touch(K_TICK, 6, 0, 1023, 32'h0000_0200);           // long press across wrap
        push_touch(K_TICK, 9, 512, 512, 32'h0000_0300);          // already fired
        push_touch(K_UP, 5, 0, 0, 32'h0000_0400);
        push_touch(K_DOWN, 1, 10, 20, 1000);
        push_touch(K_MOVE, 1, 10, 20, 1010);                     // same cell
        push_touch(K_MOVE, 1, 15, 18, 1020);                     // drag
        push_touch(K_UP, 1, 0, 0, 1030);
        push_touch(K_DOWN, 2, 0, 50, 2000);
        push_touch(K_MOVE, 2, 5, 50, 2010);                      // swipe from left
        push_touch(K_MOVE, 9, 1, 1, 2020);                       // unknown finger
        push_touch(K_DOWN, 4, 100, 100, 2030);
        push_touch(K_DOWN, 7, 300, 300, 2040);                   // both slots busy
        push_touch(K_MOVE, 2, 6, 50, 2045);                      // other finger unmoved
        push_touch(K_MOVE, 4, 110, 105, 2050);                   // scroll, wheel
        push_touch(K_MOVE, 4, 112, 105, 2055);                   // scroll, no wheel
        push_touch(K_MOVE, 4, 90, 95, 2060);                     // pinch
        push_touch(K_DOWN, 4, 200, 200, 2070);                   // restart active finger
        push_touch(K_TICK, 0, 0, 0, 2080);                       // two fingers
        push_touch(K_CANCEL, 10, 700, 300, 2090);
        push_touch(K_UNUSED_LO, 12, 1, 2, 2100);
        push_touch(K_UNUSED_HI, 13, 3, 4, 2110);
        push_touch(K_UP, 2, 0, 0, 2120);                         // finger gone after cancel

        for (int p = 0; p < PHASES; p++) begin
            // sender holds off until every result is back, then the block is idle
            wait_drained();
            repeat (4) @(posedge i_clk);
            case (p)
                0: begin
                    write_reg(CFG_TAP_LIMIT, 300);
                    write_reg(CFG_LONG_PRESS, 500);
                    write_reg(CFG_GRID_W, 640);
                    write_reg(CFG_GRID_H, 480);
                end
                1: begin
                    write_reg(CFG_TAP_LIMIT, 0);
                    write_reg(CFG_LONG_PRESS, 0);
                    write_reg(CFG_GRID_W, 1024);
                    write_reg(CFG_GRID_H, 1024);
                end
                2: begin
                    write_reg(CFG_TAP_LIMIT, 16'hFFFF);
                    write_reg(CFG_LONG_PRESS, 16'hFFFF);
                    write_reg(CFG_GRID_W, 1);
                    write_reg(CFG_GRID_H, 1);
                end
                3: begin
                    write_reg(CFG_TAP_LIMIT, 150);
                    write_reg(CFG_LONG_PRESS, 250);
                    write_reg(CFG_GRID_W, 0);
                    write_reg(CFG_GRID_H, 0);
                end
                4: begin
                    write_reg(CFG_TAP_LIMIT, 16'($urandom_range(0, 1000)));
                    write_reg(CFG_LONG_PRESS, 16'($urandom_range(0, 2000)));
                    write_reg(CFG_GRID_W, 16'($urandom_range(0, 1024)));
                    write_reg(CFG_GRID_H, 16'($urandom_range(0, 1024)));
                end
                default: begin
                    write_reg(CFG_TAP_LIMIT, 400);
                    write_reg(CFG_LONG_PRESS, 300);
                    write_reg(CFG_GRID_W, 32);
                    write_reg(CFG_GRID_H, 24);
                end
            endcase
            @(negedge i_clk);
            tx_steady = (p == 1 || p == 3);
            rx_steady = (p == 2 || p == 3);
            for (int k = 0; k < 3; k++) pool[k] = 4'($urandom_range(0, 15));
            gen_ms = ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_F000 + $urandom_range(0, 4095);
            random_touches(PHASE_ITEMS);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ touch_gesture_recognizer.f @@
rtl/tgr_pkg.sv
rtl/tgr_engine.sv
rtl/tgr_obuf.sv
rtl/touch_gesture_recognizer.sv
sim/tb_touch_gesture_recognizer.sv
